>>> rtl/core/vfur_pkg.sv
// vfur_pkg: shared types and constants for the vertex first-use reorder block
// word layouts of both channels, request codes, map entry layout, controller states
// no dependencies

package vfur_pkg;

  localparam int unsigned VID_W            = 16;
  localparam int unsigned COUNT_W          = 17;
  localparam int unsigned COORD_W          = 32;
  localparam int unsigned EPOCH_W          = 8;
  localparam int unsigned MAX_VERTICES_DEF = 65536;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 17'd65536;
  localparam logic [COUNT_W-1:0] NEXT_ID_MAX      = 17'h1FFFF;
  localparam logic [EPOCH_W-1:0] EPOCH_CLEARED    = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST      = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST       = '1;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_INDEX  = 2'd1,
    REQ_VERTEX = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [VID_W-1:0]   vertex_id;
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [COORD_W-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic [VID_W-1:0]   new_index;
    logic               was_unreferenced;
    logic               bad_index;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;
  } out_word_t;

  // one map entry: epoch tag that marks it assigned in the current mesh, and its id
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [VID_W-1:0]   id;
  } map_entry_t;

  localparam int unsigned ENTRY_W = $bits(map_entry_t);

endpackage

>>> rtl/core/vfur_map_ram.sv
// vfur_map_ram: single-clock map memory, one write and one read port
// read data registered
// depends on nothing

module vfur_map_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/vertex_first_use_reorder.sv
// vertex_first_use_reorder: index and vertex item words are remapped via the map read and
// the output register; the lookup reads then writes the map and output back-pressure holds it,
// and no new word is taken until it is done; a start or unused code needs no lookup; every
// 255th start and every reset run a clear of all MAX_VERTICES entries before a word is taken
// async active-low reset; the count register resets to 65536; configuration is taken at any time
// depends on vfur_pkg and vfur_map_ram

module vertex_first_use_reorder #(
  parameter int unsigned MAX_VERTICES = vfur_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  vfur_pkg::in_word_t                in_word_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vfur_pkg::out_word_t               out_word_o,
  // vertex_count register
  input  logic                              cfg_we_i,
  input  logic [vfur_pkg::COUNT_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  // the map lives in one memory; each entry is tagged with the epoch of the mesh that
  // assigned it, so a start only bumps the epoch and zeroes the id counter. when the epoch
  // runs out a clearing sweep writes the cleared tag everywhere and restarts at the first epoch

  vfur_pkg::state_e state_q, state_d;

  logic [vfur_pkg::COUNT_W-1:0] vcount_q;
  logic [vfur_pkg::COUNT_W-1:0] next_id_q, next_id_d;
  logic [vfur_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic [AW-1:0]                clr_addr_q;

  vfur_pkg::in_word_t  item_q;
  logic                bad_q;
  logic                out_valid_q;
  vfur_pkg::out_word_t out_q;
  vfur_pkg::out_word_t out_d;

  // handshakes
  logic in_fire;
  logic is_lookup_req;
  logic is_start_req;
  logic out_free;
  logic lookup_done;
  logic clr_last;

  // fsm outputs
  logic clearing;
  logic in_stall;
  logic rd_en;

  // memory side
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  vfur_pkg::map_entry_t mem_wdata;
  logic [AW-1:0]        vid_addr;
  logic [AW-1:0]        item_addr;
  vfur_pkg::map_entry_t rd_entry;
  logic [vfur_pkg::ENTRY_W-1:0] rd_bits;

  // lookup resolution
  logic                          hit;
  logic                          fresh;
  logic [vfur_pkg::VID_W-1:0]    id_sel;
  logic                          in_bad;
  logic [AW+vfur_pkg::VID_W-1:0] vid_ext;
  logic [AW+vfur_pkg::VID_W-1:0] item_ext;

  assign in_fire       = in_valid_i && !in_stall;
  assign is_lookup_req = (in_word_i.req_type == vfur_pkg::REQ_INDEX)
                      || (in_word_i.req_type == vfur_pkg::REQ_VERTEX);
  assign is_start_req  = (in_word_i.req_type == vfur_pkg::REQ_START);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign lookup_done   = (state_q == vfur_pkg::ST_LOOKUP) && out_free;
  assign clr_last      = (clr_addr_q == LAST_ADDR);

  // vertex ids widened or cut to the map address; out-of-range ids are never written to the map
  assign vid_ext   = {{AW{1'b0}}, in_word_i.vertex_id};
  assign vid_addr  = vid_ext[AW-1:0];
  assign item_ext  = {{AW{1'b0}}, item_q.vertex_id};
  assign item_addr = item_ext[AW-1:0];

  // range check against the register and the map size
  assign in_bad = ({1'b0, in_word_i.vertex_id} >= vcount_q)
               || (32'(in_word_i.vertex_id) >= 32'(MAX_VERTICES));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfur_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = vfur_pkg::ST_IDLE;
        end
      end
      vfur_pkg::ST_IDLE: begin
        if (in_valid_i && is_lookup_req) begin
          state_d = vfur_pkg::ST_LOOKUP;
        end else if (in_valid_i && is_start_req && (epoch_q == vfur_pkg::EPOCH_LAST)) begin
          state_d = vfur_pkg::ST_CLEAR;
        end
      end
      vfur_pkg::ST_LOOKUP: begin
        if (out_free) begin
          state_d = vfur_pkg::ST_IDLE;
        end
      end
      default: state_d = vfur_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- fsm outputs
  always_comb begin
    clearing = 1'b0;
    in_stall = 1'b1;
    rd_en    = 1'b0;
    unique case (state_q)
      vfur_pkg::ST_CLEAR: begin
        clearing = 1'b1;
      end
      vfur_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid_i && is_lookup_req;
      end
      vfur_pkg::ST_LOOKUP: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_stall_o = in_stall;

  // ---------------------------------------------------------------- map memory
  assign rd_entry = vfur_pkg::map_entry_t'(rd_bits);

  // an entry counts as assigned only if its tag matches the live epoch
  assign hit    = (rd_entry.tag == epoch_q);
  assign fresh  = !hit && !bad_q;
  assign id_sel = hit ? rd_entry.id : next_id_q[vfur_pkg::VID_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_addr;
    mem_wdata = '{tag: epoch_q, id: id_sel};
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '{tag: vfur_pkg::EPOCH_CLEARED, id: '0};
    end else if (lookup_done && fresh) begin
      mem_we = 1'b1;
    end
  end

  vfur_map_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .DW    (vfur_pkg::ENTRY_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (vid_addr),
    .rdata_o (rd_bits)
  );

  // ---------------------------------------------------------------- id counter and epoch
  always_comb begin
    next_id_d = next_id_q;
    epoch_d   = epoch_q;
    if (in_fire && is_start_req) begin
      next_id_d = '0;
      // last epoch used up: the sweep wipes the tags, then counting starts over
      epoch_d   = (epoch_q == vfur_pkg::EPOCH_LAST) ? vfur_pkg::EPOCH_FIRST
                                                     : epoch_q + 1'b1;
    end else if (lookup_done && fresh && (next_id_q != vfur_pkg::NEXT_ID_MAX)) begin
      next_id_d = next_id_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= vfur_pkg::ST_CLEAR;
      vcount_q   <= vfur_pkg::VERTEX_COUNT_RST;
      next_id_q  <= '0;
      epoch_q    <= vfur_pkg::EPOCH_FIRST;
      clr_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      epoch_q   <= epoch_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_data_i;
      end
      if (clearing) begin
        clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
      end
      if (lookup_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      item_q <= in_word_i;
      bad_q  <= in_bad;
    end
  end

  // result word: bad ids carry only the flag, coordinates only for vertex items
  always_comb begin
    out_d = '0;
    if (bad_q) begin
      out_d.bad_index = 1'b1;
    end else begin
      out_d.new_index = id_sel;
      if (item_q.req_type == vfur_pkg::REQ_VERTEX) begin
        out_d.was_unreferenced = fresh;
        out_d.out_x = item_q.in_x;
        out_d.out_y = item_q.in_y;
        out_d.out_z = item_q.in_z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_done) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
